// ----- sv/riscv_instruction_classifier_core_assert.svh -----
// ----------------------------------------------------------------------------
// Instruction classifier assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RISCV_INSTRUCTION_CLASSIFIER_CORE_ASSERT_SVH
`define RISCV_INSTRUCTION_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define RIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("classifier assertion failed");

// next-cycle implication
`define RIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("classifier assertion failed");

`endif

// ----- sv/ric_pkg.sv -----
// ----------------------------------------------------------------------------
// Instruction classifier package
// Item types, opcode, class and operation codes, and funct3 lookup tables.
// ----------------------------------------------------------------------------
package ric_pkg;

    localparam logic [6:0] OP_LUI      = 7'h37;
    localparam logic [6:0] OP_UPPER_PC = 7'h17;
    localparam logic [6:0] OP_JAL      = 7'h6f;
    localparam logic [6:0] OP_JALR     = 7'h67;
    localparam logic [6:0] OP_COND_BR  = 7'h63;
    localparam logic [6:0] OP_LOAD     = 7'h03;
    localparam logic [6:0] OP_MEM_WR   = 7'h23;
    localparam logic [6:0] OP_IMM      = 7'h13;
    localparam logic [6:0] OP_REG      = 7'h33;
    localparam logic [6:0] OP_IMM_W    = 7'h1b;
    localparam logic [6:0] OP_REG_W    = 7'h3b;
    localparam logic [6:0] OP_MISC_MEM = 7'h0f;
    localparam logic [6:0] OP_SYS      = 7'h73;
    localparam logic [6:0] OP_AMO      = 7'h2f;
    localparam logic [6:0] OP_LOAD_FP  = 7'h07;
    localparam logic [6:0] OP_FP_MEM_WR = 7'h27;
    localparam logic [6:0] OP_FP_MADD  = 7'h43;
    localparam logic [6:0] OP_FP_MSUB  = 7'h47;
    localparam logic [6:0] OP_FP_NMSUB = 7'h4b;
    localparam logic [6:0] OP_FP_NMADD = 7'h4f;
    localparam logic [6:0] OP_FP       = 7'h53;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SRL = 3'd5;
    localparam logic [2:0] F3_FENCE_I = 3'd1;
    localparam logic [2:0] F3_LOAD_BAD = 3'd7;
    localparam logic [11:0] SYS_ECALL = 12'd0;
    localparam logic [11:0] SYS_EBREAK = 12'd1;

    typedef enum logic [4:0] {
        CLS_INVALID     = 5'd0,
        CLS_UNSUPPORTED = 5'd1,
        CLS_LUI         = 5'd2,
        CLS_AUIPC       = 5'd3,
        CLS_JAL         = 5'd4,
        CLS_JALR        = 5'd5,
        CLS_BRANCH      = 5'd6,
        CLS_LOAD        = 5'd7,
        CLS_STORE       = 5'd8,
        CLS_ALU_IMM     = 5'd9,
        CLS_SHIFT_IMM   = 5'd10,
        CLS_ALU_REG     = 5'd11,
        CLS_FENCE       = 5'd12,
        CLS_ECALL       = 5'd13,
        CLS_EBREAK      = 5'd14,
        CLS_ALU_IMM_W   = 5'd15,
        CLS_ALU_REG_W   = 5'd16,
        CLS_MUL         = 5'd17,
        CLS_DIV         = 5'd18,
        CLS_CSR         = 5'd19,
        CLS_PRIV        = 5'd20,
        CLS_FENCE_I     = 5'd21,
        CLS_FLOAT       = 5'd22
    } t_insn_class;

    localparam logic [4:0] ALU_ADD  = 5'd0;
    localparam logic [4:0] ALU_SUB  = 5'd1;
    localparam logic [4:0] ALU_SLL  = 5'd2;
    localparam logic [4:0] ALU_SLT  = 5'd3;
    localparam logic [4:0] ALU_LTU  = 5'd4;
    localparam logic [4:0] ALU_XOR  = 5'd5;
    localparam logic [4:0] ALU_SRL  = 5'd6;
    localparam logic [4:0] ALU_SRA  = 5'd7;
    localparam logic [4:0] ALU_OR   = 5'd8;
    localparam logic [4:0] ALU_AND  = 5'd9;
    localparam logic [4:0] ALU_MUL  = 5'd10;
    localparam logic [4:0] ALU_DIV  = 5'd14;

    localparam logic [2:0] BR_BEQ  = 3'd0;
    localparam logic [2:0] BR_BNE  = 3'd1;
    localparam logic [2:0] BR_BLT  = 3'd2;
    localparam logic [2:0] BR_BGE  = 3'd3;
    localparam logic [2:0] BR_BLTU = 3'd4;
    localparam logic [2:0] BR_BGEU = 3'd5;
    localparam logic [2:0] BR_NONE = 3'd7;

    typedef struct packed {
        logic [31:0] instruction_word;
        logic [31:0] program_counter;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        raw_word;
        logic [31:0]        pc_out;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_one;
        logic [4:0]         src_reg_two;
        t_insn_class        insn_class;
        logic [4:0]         alu_operation;
        logic [2:0]         access_kind;
        logic signed [31:0] immediate;
        logic               word_operation;
        logic               permitted;
    } t_out_item;

    function automatic logic [4:0] base_op(input logic [2:0] f3);
        logic [4:0] op;
        case (f3)
            3'd0: op = ALU_ADD;
            3'd1: op = ALU_SLL;
            3'd2: op = ALU_SLT;
            3'd3: op = ALU_LTU;
            3'd4: op = ALU_XOR;
            3'd5: op = ALU_SRL;
            3'd6: op = ALU_OR;
            default: op = ALU_AND;
        endcase
        return op;
    endfunction

    function automatic logic [2:0] branch_kind(input logic [2:0] f3);
        logic [2:0] kind;
        case (f3)
            3'd0: kind = BR_BEQ;
            3'd1: kind = BR_BNE;
            3'd4: kind = BR_BLT;
            3'd5: kind = BR_BGE;
            3'd6: kind = BR_BLTU;
            3'd7: kind = BR_BGEU;
            default: kind = BR_NONE;
        endcase
        return kind;
    endfunction

endpackage

// ----- sv/riscv_instruction_classifier_core.sv -----
// ----------------------------------------------------------------------------
// RISC-V instruction classifier core
// Decodes one 32-bit RV64IM instruction word per item into register fields,
// class, ALU operation, access kind, immediate and policy flags.
// Each accepted item enters the input reg, then the result reg once out_take allows.
// Throughput: 1 item per cycle while i_out_ready stays high; a stall holds the
// result reg, and the input reg too once it is full.
// Reset: synchronous active-low i_rst_n clears both stage valid flags.
// ----------------------------------------------------------------------------
`include "riscv_instruction_classifier_core_assert.svh"

module riscv_instruction_classifier_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ric_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ric_pkg::t_out_item o_out_item
);
    import ric_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      out_take;
    logic      in_take;

    logic [31:0] w;
    logic [6:0]  opcode;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [2:0]  br_kind;

    assign out_take   = !r_out_valid || i_out_ready;
    assign in_take    = !r_in_valid || out_take;
    assign o_in_ready = in_take;

    assign w       = r_in.instruction_word;
    assign opcode  = w[6:0];
    assign f3      = w[14:12];
    assign f7      = w[31:25];
    assign imm_i   = {{20{w[31]}}, w[31:20]};
    assign imm_s   = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b   = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u   = {w[31:12], 12'b0};
    assign imm_j   = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign br_kind = branch_kind(f3);

    always_comb begin
        n_out                = '0;
        n_out.raw_word       = w;
        n_out.pc_out         = r_in.program_counter;
        n_out.dest_reg       = w[11:7];
        n_out.src_reg_one    = w[19:15];
        n_out.src_reg_two    = w[24:20];
        n_out.insn_class     = CLS_INVALID;
        if (w[1:0] != 2'b11) begin
            n_out.dest_reg    = '0;
            n_out.src_reg_one = '0;
            n_out.src_reg_two = '0;
            n_out.insn_class  = CLS_UNSUPPORTED;
        end else begin
            case (opcode)
                OP_LUI: begin
                    n_out.insn_class = CLS_LUI;
                    n_out.immediate  = imm_u;
                end
                OP_UPPER_PC: begin
                    n_out.insn_class = CLS_AUIPC;
                    n_out.immediate  = imm_u;
                end
                OP_JAL: begin
                    n_out.insn_class = CLS_JAL;
                    n_out.immediate  = imm_j;
                end
                OP_JALR: begin
                    if (f3 == F3_ADD) begin
                        n_out.insn_class = CLS_JALR;
                        n_out.immediate  = imm_i;
                    end
                end
                OP_COND_BR: begin
                    if (br_kind != BR_NONE) begin
                        n_out.insn_class  = CLS_BRANCH;
                        n_out.access_kind = br_kind;
                        n_out.immediate   = imm_b;
                    end
                end
                OP_LOAD: begin
                    if (f3 != F3_LOAD_BAD) begin
                        n_out.insn_class  = CLS_LOAD;
                        n_out.access_kind = f3;
                        n_out.immediate   = imm_i;
                    end
                end
                OP_MEM_WR: begin
                    if (!f3[2]) begin
                        n_out.insn_class  = CLS_STORE;
                        n_out.access_kind = f3;
                        n_out.immediate   = imm_s;
                    end
                end
                OP_IMM: begin
                    if (f3 == F3_SLL || f3 == F3_SRL) begin
                        n_out.insn_class    = CLS_SHIFT_IMM;
                        n_out.alu_operation = (f3 == F3_SLL) ? ALU_SLL :
                                              (w[30] ? ALU_SRA : ALU_SRL);
                        n_out.immediate     = {26'b0, w[25:20]};
                    end else begin
                        n_out.insn_class    = CLS_ALU_IMM;
                        n_out.alu_operation = base_op(f3);
                        n_out.immediate     = imm_i;
                    end
                end
                OP_REG: begin
                    if (f7 == F7_MULDIV) begin
                        n_out.insn_class    = f3[2] ? CLS_DIV : CLS_MUL;
                        n_out.alu_operation = ALU_MUL + {2'b0, f3};
                    end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)) begin
                        n_out.insn_class    = CLS_ALU_REG;
                        n_out.alu_operation = (f3 == F3_ADD) ? ALU_SUB : ALU_SRA;
                    end else if (f7 == F7_BASE) begin
                        n_out.insn_class    = CLS_ALU_REG;
                        n_out.alu_operation = base_op(f3);
                    end
                end
                OP_IMM_W: begin
                    if (f3 == F3_ADD) begin
                        n_out.insn_class     = CLS_ALU_IMM_W;
                        n_out.alu_operation  = ALU_ADD;
                        n_out.immediate      = imm_i;
                        n_out.word_operation = 1'b1;
                    end else if (f3 == F3_SLL || f3 == F3_SRL) begin
                        n_out.insn_class     = CLS_ALU_IMM_W;
                        n_out.alu_operation  = (f3 == F3_SLL) ? ALU_SLL :
                                               (w[30] ? ALU_SRA : ALU_SRL);
                        n_out.immediate      = {27'b0, w[24:20]};
                        n_out.word_operation = 1'b1;
                    end
                end
                OP_REG_W: begin
                    if (f7 == F7_MULDIV) begin
                        if (f3 == F3_ADD) begin
                            n_out.insn_class     = CLS_MUL;
                            n_out.alu_operation  = ALU_MUL;
                            n_out.word_operation = 1'b1;
                        end else if (f3[2]) begin
                            n_out.insn_class     = CLS_DIV;
                            n_out.alu_operation  = ALU_DIV + {3'b0, f3[1:0]};
                            n_out.word_operation = 1'b1;
                        end
                    end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)) begin
                        n_out.insn_class     = CLS_ALU_REG_W;
                        n_out.alu_operation  = (f3 == F3_ADD) ? ALU_SUB : ALU_SRA;
                        n_out.word_operation = 1'b1;
                    end else if (f7 == F7_BASE &&
                                 (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SRL)) begin
                        n_out.insn_class     = CLS_ALU_REG_W;
                        n_out.alu_operation  = base_op(f3);
                        n_out.word_operation = 1'b1;
                    end
                end
                OP_MISC_MEM: begin
                    n_out.insn_class = (f3 == F3_FENCE_I) ? CLS_FENCE_I : CLS_FENCE;
                end
                OP_SYS: begin
                    if (f3 == F3_ADD && w[11:7] == 5'd0 && w[19:15] == 5'd0) begin
                        if (w[31:20] == SYS_ECALL) begin
                            n_out.insn_class = CLS_ECALL;
                        end else if (w[31:20] == SYS_EBREAK) begin
                            n_out.insn_class = CLS_EBREAK;
                        end else begin
                            n_out.insn_class = CLS_PRIV;
                        end
                    end else begin
                        n_out.insn_class = CLS_CSR;
                    end
                end
                OP_AMO: begin
                    n_out.insn_class = CLS_UNSUPPORTED;
                end
                OP_LOAD_FP, OP_FP_MEM_WR, OP_FP_MADD, OP_FP_MSUB,
                OP_FP_NMSUB, OP_FP_NMADD, OP_FP: begin
                    n_out.insn_class = CLS_FLOAT;
                end
                default: begin
                    n_out.insn_class = CLS_INVALID;
                end
            endcase
        end
        n_out.permitted = ((n_out.insn_class >= CLS_LUI && n_out.insn_class <= CLS_ECALL) ||
                           (n_out.insn_class >= CLS_ALU_IMM_W &&
                            n_out.insn_class <= CLS_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (out_take) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (out_take && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `RIC_ASSERT_NEXT(a_advance, r_in_valid && out_take,
        r_out_valid && r_out.raw_word == $past(r_in.instruction_word))
    `RIC_ASSERT_SAME(a_invalid_clean, r_out_valid && r_out.insn_class == CLS_INVALID,
        r_out.alu_operation == 5'd0 && r_out.access_kind == 3'd0 &&
        r_out.immediate == 32'sd0 && !r_out.word_operation && !r_out.permitted)
    `RIC_ASSERT_SAME(a_compressed_regs, r_out_valid && r_out.raw_word[1:0] != 2'b11,
        r_out.insn_class == CLS_UNSUPPORTED && r_out.dest_reg == 5'd0 &&
        r_out.src_reg_one == 5'd0 && r_out.src_reg_two == 5'd0)
    `RIC_ASSERT_SAME(a_word_permitted, r_out_valid && r_out.word_operation,
        r_out.permitted)

endmodule

// ----- test/tb_riscv_instruction_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Instruction classifier core testbench
// Walks a table of directed instruction words, then streams random words that
// are mostly well-formed encodings. Each item is checked field by field against
// a literal row or a local decoder. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_riscv_instruction_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ric_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int RUN_LIMIT    = 500000;

    typedef struct {
        logic [31:0] word;
        logic [31:0] pc;
        bit          literal;
        t_out_item   want;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;

    logic [31:0] cycle_count = '0;
    logic        quiet_phase;
    int          stall_left = 0;
    int          mismatch_count = 0;
    t_out_item   expected_decodes[$];

    assign quiet_phase = (cycle_count[9:8] == 2'b00);

    riscv_instruction_classifier_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int idle_cycles();
        int roll;
        if (quiet_phase) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [4:0] alu_for_funct3(input logic [2:0] f3);
        case (f3)
            3'd0: return ALU_ADD;
            3'd1: return ALU_SLL;
            3'd2: return ALU_SLT;
            3'd3: return ALU_LTU;
            3'd4: return ALU_XOR;
            3'd5: return ALU_SRL;
            3'd6: return ALU_OR;
            default: return ALU_AND;
        endcase
    endfunction

    function automatic t_out_item decode_insn(input logic [31:0] w, input logic [31:0] pc);
        t_out_item   r;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [31:0] imm_i;
        r = '0;
        r.raw_word = w;
        r.pc_out = pc;
        r.insn_class = CLS_INVALID;
        f3 = w[14:12];
        f7 = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        if (w[1:0] != 2'b11) begin
            r.insn_class = CLS_UNSUPPORTED;
        end else begin
            r.dest_reg = w[11:7];
            r.src_reg_one = w[19:15];
            r.src_reg_two = w[24:20];
            case (w[6:0])
                OP_LUI: begin
                    r.insn_class = CLS_LUI;
                    r.immediate = {w[31:12], 12'h000};
                end
                OP_UPPER_PC: begin
                    r.insn_class = CLS_AUIPC;
                    r.immediate = {w[31:12], 12'h000};
                end
                OP_JAL: begin
                    r.insn_class = CLS_JAL;
                    r.immediate = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                end
                OP_JALR: begin
                    if (f3 == F3_ADD) begin
                        r.insn_class = CLS_JALR;
                        r.immediate = imm_i;
                    end
                end
                OP_COND_BR: begin
                    if (f3 != 3'd2 && f3 != 3'd3) begin
                        r.insn_class = CLS_BRANCH;
                        case (f3)
                            3'd0: r.access_kind = BR_BEQ;
                            3'd1: r.access_kind = BR_BNE;
                            3'd4: r.access_kind = BR_BLT;
                            3'd5: r.access_kind = BR_BGE;
                            3'd6: r.access_kind = BR_BLTU;
                            default: r.access_kind = BR_BGEU;
                        endcase
                        r.immediate = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                    end
                end
                OP_LOAD: begin
                    if (f3 != F3_LOAD_BAD) begin
                        r.insn_class = CLS_LOAD;
                        r.access_kind = f3;
                        r.immediate = imm_i;
                    end
                end
                OP_MEM_WR: begin
                    if (f3 < 3'd4) begin
                        r.insn_class = CLS_STORE;
                        r.access_kind = f3;
                        r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                    end
                end
                OP_IMM: begin
                    if (f3 == F3_SLL || f3 == F3_SRL) begin
                        r.insn_class = CLS_SHIFT_IMM;
                        r.alu_operation = (f3 == F3_SLL) ? ALU_SLL : (w[30] ? ALU_SRA : ALU_SRL);
                        r.immediate = {26'h0, w[25:20]};
                    end else begin
                        r.insn_class = CLS_ALU_IMM;
                        r.alu_operation = alu_for_funct3(f3);
                        r.immediate = imm_i;
                    end
                end
                OP_REG: begin
                    if (f7 == F7_MULDIV) begin
                        r.insn_class = (f3 < 3'd4) ? CLS_MUL : CLS_DIV;
                        r.alu_operation = ALU_MUL + {2'b00, f3};
                    end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)) begin
                        r.insn_class = CLS_ALU_REG;
                        r.alu_operation = (f3 == F3_ADD) ? ALU_SUB : ALU_SRA;
                    end else if (f7 == F7_BASE) begin
                        r.insn_class = CLS_ALU_REG;
                        r.alu_operation = alu_for_funct3(f3);
                    end
                end
                OP_IMM_W: begin
                    if (f3 == F3_ADD) begin
                        r.insn_class = CLS_ALU_IMM_W;
                        r.alu_operation = ALU_ADD;
                        r.immediate = imm_i;
                        r.word_operation = 1'b1;
                    end else if (f3 == F3_SLL || f3 == F3_SRL) begin
                        r.insn_class = CLS_ALU_IMM_W;
                        r.alu_operation = (f3 == F3_SLL) ? ALU_SLL : (w[30] ? ALU_SRA : ALU_SRL);
                        r.immediate = {27'h0, w[24:20]};
                        r.word_operation = 1'b1;
                    end
                end
                OP_REG_W: begin
                    if (f7 == F7_MULDIV) begin
                        if (f3 == 3'd0) begin
                            r.insn_class = CLS_MUL;
                            r.alu_operation = ALU_MUL;
                            r.word_operation = 1'b1;
                        end else if (f3 >= 3'd4) begin
                            r.insn_class = CLS_DIV;
                            r.alu_operation = ALU_DIV + {2'b00, f3} - 5'd4;
                            r.word_operation = 1'b1;
                        end
                    end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)) begin
                        r.insn_class = CLS_ALU_REG_W;
                        r.alu_operation = (f3 == F3_ADD) ? ALU_SUB : ALU_SRA;
                        r.word_operation = 1'b1;
                    end else if (f7 == F7_BASE
                                 && (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SRL)) begin
                        r.insn_class = CLS_ALU_REG_W;
                        r.alu_operation = alu_for_funct3(f3);
                        r.word_operation = 1'b1;
                    end
                end
                OP_MISC_MEM: begin
                    r.insn_class = (f3 == F3_FENCE_I) ? CLS_FENCE_I : CLS_FENCE;
                end
                OP_SYS: begin
                    if (f3 == 3'd0 && w[11:7] == 5'd0 && w[19:15] == 5'd0) begin
                        if (w[31:20] == SYS_ECALL) r.insn_class = CLS_ECALL;
                        else if (w[31:20] == SYS_EBREAK) r.insn_class = CLS_EBREAK;
                        else r.insn_class = CLS_PRIV;
                    end else begin
                        r.insn_class = CLS_CSR;
                    end
                end
                OP_AMO: r.insn_class = CLS_UNSUPPORTED;
                OP_LOAD_FP, OP_FP_MEM_WR, OP_FP_MADD, OP_FP_MSUB,
                OP_FP_NMSUB, OP_FP_NMADD, OP_FP: r.insn_class = CLS_FLOAT;
                default: ;
            endcase
        end
        r.permitted = (r.insn_class >= CLS_LUI && r.insn_class <= CLS_ECALL)
                   || (r.insn_class >= CLS_ALU_IMM_W && r.insn_class <= CLS_DIV);
        return r;
    endfunction

    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 7) == 0) return w;
        case ($urandom_range(0, 18))
            0: w[6:0] = OP_LUI;
            1: w[6:0] = OP_UPPER_PC;
            2: w[6:0] = OP_JAL;
            3: w[6:0] = OP_JALR;
            4: w[6:0] = OP_COND_BR;
            5: w[6:0] = OP_LOAD;
            6: w[6:0] = OP_MEM_WR;
            7, 8: w[6:0] = OP_IMM;
            9, 10: w[6:0] = OP_REG;
            11: w[6:0] = OP_IMM_W;
            12, 13: w[6:0] = OP_REG_W;
            14: w[6:0] = OP_MISC_MEM;
            15, 16: w[6:0] = OP_SYS;
            17: w[6:0] = OP_AMO;
            default: begin
                case ($urandom_range(0, 6))
                    0: w[6:0] = OP_LOAD_FP;
                    1: w[6:0] = OP_FP_MEM_WR;
                    2: w[6:0] = OP_FP_MADD;
                    3: w[6:0] = OP_FP_MSUB;
                    4: w[6:0] = OP_FP_NMSUB;
                    5: w[6:0] = OP_FP_NMADD;
                    default: w[6:0] = OP_FP;
                endcase
            end
        endcase
        if (w[6:0] == OP_REG || w[6:0] == OP_REG_W) begin
            case ($urandom_range(0, 3))
                0: w[31:25] = F7_BASE;
                1: w[31:25] = F7_MULDIV;
                2: w[31:25] = F7_ALT;
                default: ;
            endcase
        end
        if ((w[6:0] == OP_IMM || w[6:0] == OP_IMM_W) && $urandom_range(0, 1) == 1) begin
            w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
        end
        if (w[6:0] == OP_JALR && $urandom_range(0, 3) != 0) begin
            w[14:12] = F3_ADD;
        end
        if (w[6:0] == OP_SYS && $urandom_range(0, 1) == 1) begin
            w[19:7] = '0;
            case ($urandom_range(0, 2))
                0: w[31:20] = SYS_ECALL;
                1: w[31:20] = SYS_EBREAK;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_count, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            int gap;
            gap = idle_cycles();
            if (gap == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                stall_left <= gap - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_decodes.size() == 0) begin
                flag_mismatch("unexpected item, raw_word", 32'h0, o_out_item.raw_word);
            end else begin
                want = expected_decodes.pop_front();
                if (o_out_item.raw_word !== want.raw_word)
                    flag_mismatch("raw_word", want.raw_word, o_out_item.raw_word);
                if (o_out_item.pc_out !== want.pc_out)
                    flag_mismatch("pc_out", want.pc_out, o_out_item.pc_out);
                if (o_out_item.dest_reg !== want.dest_reg)
                    flag_mismatch("dest_reg", 32'(want.dest_reg),
                                  32'(o_out_item.dest_reg));
                if (o_out_item.src_reg_one !== want.src_reg_one)
                    flag_mismatch("src_reg_one", 32'(want.src_reg_one),
                                  32'(o_out_item.src_reg_one));
                if (o_out_item.src_reg_two !== want.src_reg_two)
                    flag_mismatch("src_reg_two", 32'(want.src_reg_two),
                                  32'(o_out_item.src_reg_two));
                if (o_out_item.insn_class !== want.insn_class)
                    flag_mismatch("insn_class", 32'(want.insn_class),
                                  32'(o_out_item.insn_class));
                if (o_out_item.alu_operation !== want.alu_operation)
                    flag_mismatch("alu_operation", 32'(want.alu_operation),
                                  32'(o_out_item.alu_operation));
                if (o_out_item.access_kind !== want.access_kind)
                    flag_mismatch("access_kind", 32'(want.access_kind),
                                  32'(o_out_item.access_kind));
                if (o_out_item.immediate !== want.immediate)
                    flag_mismatch("immediate", want.immediate, o_out_item.immediate);
                if (o_out_item.word_operation !== want.word_operation)
                    flag_mismatch("word_operation", 32'(want.word_operation),
                                  32'(o_out_item.word_operation));
                if (o_out_item.permitted !== want.permitted)
                    flag_mismatch("permitted", 32'(want.permitted),
                                  32'(o_out_item.permitted));
            end
        end
    end

    task automatic send_insn(input logic [31:0] word, input logic [31:0] pc,
                             input bit literal, input t_out_item want);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{instruction_word: word, program_counter: pc};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_decodes.push_back(literal ? want : decode_insn(word, pc));
    endtask

    task automatic drain_decodes();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_decodes.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_dir_row dir_rows[26];
        dir_rows[0]  = '{32'h0000_0000, 32'h0000_0000, 1'b1,
                         '{32'h0000_0000, 32'h0000_0000, 5'd0, 5'd0, 5'd0, CLS_UNSUPPORTED,
                           ALU_ADD, 3'd0, 32'sd0, 1'b0, 1'b0}};
        dir_rows[1]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 5'd31, 5'd31, CLS_INVALID,
                           ALU_ADD, 3'd0, 32'sd0, 1'b0, 1'b0}};
        dir_rows[2]  = '{32'h0000_0073, 32'h8000_0000, 1'b1,
                         '{32'h0000_0073, 32'h8000_0000, 5'd0, 5'd0, 5'd0, CLS_ECALL,
                           ALU_ADD, 3'd0, 32'sd0, 1'b0, 1'b1}};
        dir_rows[3]  = '{32'h0010_0073, 32'h7FFF_FFFC, 1'b1,
                         '{32'h0010_0073, 32'h7FFF_FFFC, 5'd0, 5'd0, 5'd1, CLS_EBREAK,
                           ALU_ADD, 3'd0, 32'sd0, 1'b0, 1'b0}};
        dir_rows[4]  = '{32'h0000_202F, 32'h0000_1000, 1'b1,
                         '{32'h0000_202F, 32'h0000_1000, 5'd0, 5'd0, 5'd0, CLS_UNSUPPORTED,
                           ALU_ADD, 3'd0, 32'sd0, 1'b0, 1'b0}};
        dir_rows[5]  = '{32'h0000_7003, 32'h0000_0004, 1'b1,
                         '{32'h0000_7003, 32'h0000_0004, 5'd0, 5'd0, 5'd0, CLS_INVALID,
                           ALU_ADD, 3'd0, 32'sd0, 1'b0, 1'b0}};
        dir_rows[6]  = '{32'h1050_0073, 32'h0000_0008, 1'b0, '0};
        dir_rows[7]  = '{32'h3410_2573, 32'h0000_000C, 1'b0, '0};
        dir_rows[8]  = '{32'hFFFF_F0B7, 32'h0000_0010, 1'b0, '0};
        dir_rows[9]  = '{32'h0000_1017, 32'hAAAA_AAAA, 1'b0, '0};
        dir_rows[10] = '{32'h8000_006F, 32'h5555_5555, 1'b0, '0};
        dir_rows[11] = '{32'h7FFF_F0EF, 32'h0000_0014, 1'b0, '0};
        dir_rows[12] = '{32'hFFF0_8067, 32'h0000_0018, 1'b0, '0};
        dir_rows[13] = '{32'h0000_9067, 32'h0000_001C, 1'b0, '0};
        dir_rows[14] = '{32'hFE00_7FE3, 32'h0000_0020, 1'b0, '0};
        dir_rows[15] = '{32'h0000_2063, 32'h0000_0024, 1'b0, '0};
        dir_rows[16] = '{32'hFE00_3FA3, 32'h0000_0028, 1'b0, '0};
        dir_rows[17] = '{32'h0000_4023, 32'h0000_002C, 1'b0, '0};
        dir_rows[18] = '{32'h43F0_5093, 32'h0000_0030, 1'b0, '0};
        dir_rows[19] = '{32'hFFF0_7013, 32'h0000_0034, 1'b0, '0};
        dir_rows[20] = '{32'h4000_5033, 32'h0000_0038, 1'b0, '0};
        dir_rows[21] = '{32'h0200_703B, 32'h0000_003C, 1'b0, '0};
        dir_rows[22] = '{32'h0200_103B, 32'h0000_0040, 1'b0, '0};
        dir_rows[23] = '{32'h41F0_501B, 32'h0000_0044, 1'b0, '0};
        dir_rows[24] = '{32'h0000_100F, 32'h0000_0048, 1'b0, '0};
        dir_rows[25] = '{32'h0000_0053, 32'h0000_004C, 1'b0, '0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_insn(dir_rows[k].word, dir_rows[k].pc, dir_rows[k].literal, dir_rows[k].want);
        end
        drain_decodes();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_decodes();
            send_insn(random_insn(), $urandom, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0 && expected_decodes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
